FILE: rtl/stx_pkg.sv
package stx_pkg;

  localparam int COORD_W     = 12;
  localparam int DIM_REG_W   = 13;
  localparam int STEP_W      = 10;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 2;
  localparam int PIXEL_W     = 8;

  localparam int SCALE_DEF   = 12;
  localparam int MAX_DIM_DEF = 4096;

  localparam int GLYPH_COUNT = 9;
  localparam int GLYPH_ROWS  = 7;
  localparam int GLYPH_COLS  = 5;

  localparam logic [DIM_REG_W-1:0] WIDTH_RST  = 13'd1920;
  localparam logic [DIM_REG_W-1:0] HEIGHT_RST = 13'd1080;
  localparam logic [STEP_W-1:0]    STEP_RST   = 10'd8;

  localparam logic [PIXEL_W-1:0] PIXEL_ON  = 8'd255;
  localparam logic [PIXEL_W-1:0] PIXEL_OFF = 8'd0;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_SCROLL_STEP  = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [DIM_REG_W-1:0] frame_width;
    logic [DIM_REG_W-1:0] frame_height;
    logic [STEP_W-1:0]    scroll_step;
  } cfg_t;

  // 5x7 rows per glyph, top row first, bit 4 is the leftmost column
  localparam logic [GLYPH_COLS-1:0] GLYPH_ROM [GLYPH_COUNT][GLYPH_ROWS] = '{
    '{5'h0E, 5'h10, 5'h1C, 5'h02, 5'h02, 5'h12, 5'h0C},
    '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04},
    '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F},
    '{5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11},
    '{5'h00, 5'h0E, 5'h10, 5'h0C, 5'h02, 5'h1C, 5'h00},
    '{5'h00, 5'h0E, 5'h10, 5'h10, 5'h10, 5'h0E, 5'h00},
    '{5'h00, 5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E, 5'h00},
    '{5'h00, 5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10},
    '{5'h00, 5'h0E, 5'h11, 5'h1F, 5'h10, 5'h0E, 5'h00}
  };

endpackage

FILE: rtl/stx_in_if.sv
interface stx_in_if;
  logic                        valid;
  logic                        ready;
  logic [stx_pkg::COORD_W-1:0] column;
  logic [stx_pkg::COORD_W-1:0] buffer_row;
  logic                        frame_end;

  modport source (output valid, output column, output buffer_row, output frame_end,
                  input ready);
  modport sink (input valid, input column, input buffer_row, input frame_end,
                output ready);
endinterface

FILE: rtl/stx_out_if.sv
interface stx_out_if;
  logic                        valid;
  logic                        ready;
  logic [stx_pkg::PIXEL_W-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink (input valid, input pixel_value, output ready);
endinterface

FILE: rtl/stx_cfg_regs.sv
module stx_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [stx_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [stx_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output stx_pkg::cfg_t                   cfg
);

  stx_pkg::cfg_t cfg_r;
  stx_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        stx_pkg::REG_FRAME_WIDTH:  cfg_nxt.frame_width  = cfg_wdata;
        stx_pkg::REG_FRAME_HEIGHT: cfg_nxt.frame_height = cfg_wdata;
        stx_pkg::REG_SCROLL_STEP:  cfg_nxt.scroll_step  = cfg_wdata[stx_pkg::STEP_W-1:0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width  <= stx_pkg::WIDTH_RST;
      cfg_r.frame_height <= stx_pkg::HEIGHT_RST;
      cfg_r.scroll_step  <= stx_pkg::STEP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/stx_scroll.sv
module stx_scroll #(
  parameter int SCALE   = stx_pkg::SCALE_DEF,
  parameter int MAX_DIM = stx_pkg::MAX_DIM_DEF,
  localparam int OFS_W  = $clog2(MAX_DIM + 1024) + 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    advance,
  input  stx_pkg::cfg_t           cfg,
  output logic signed [OFS_W-1:0] offset
);

  localparam int TEXT_W = stx_pkg::GLYPH_COUNT * 6 * SCALE - SCALE;
  localparam int AW     = (OFS_W + 2 > 15) ? OFS_W + 2 : 15;

  logic signed [OFS_W-1:0] offset_r;
  logic signed [OFS_W-1:0] offset_nxt;
  logic signed [AW-1:0]    fw;
  logic signed [AW-1:0]    w;
  logic signed [AW-1:0]    sum;

  always_comb begin
    fw  = $signed(AW'(cfg.frame_width));
    w   = (fw > AW'(MAX_DIM)) ? AW'(MAX_DIM) : fw;
    sum = AW'(offset_r) + $signed(AW'(cfg.scroll_step));
    offset_nxt = offset_r;
    if (advance) begin
      // wrap to just left of the frame once past the right edge
      if (sum > w) begin
        offset_nxt = OFS_W'(-TEXT_W);
      end else begin
        offset_nxt = sum[OFS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
    end else begin
      offset_r <= offset_nxt;
    end
  end

  assign offset = offset_r;

endmodule

FILE: rtl/stx_pixel_core.sv
module stx_pixel_core #(
  parameter int SCALE   = stx_pkg::SCALE_DEF,
  parameter int MAX_DIM = stx_pkg::MAX_DIM_DEF,
  localparam int OFS_W  = $clog2(MAX_DIM + 1024) + 1
) (
  input  logic [stx_pkg::COORD_W-1:0] column,
  input  logic [stx_pkg::COORD_W-1:0] buffer_row,
  input  stx_pkg::cfg_t               cfg,
  input  logic signed [OFS_W-1:0]     offset,
  output logic                        lit
);

  localparam int CELL_PITCH = 6 * SCALE;
  localparam int TEXT_W     = stx_pkg::GLYPH_COUNT * CELL_PITCH - SCALE;
  localparam int TEXT_H     = stx_pkg::GLYPH_ROWS * SCALE;
  localparam int AW         = (OFS_W + 2 > 15) ? OFS_W + 2 : 15;
  localparam int DXW        = $clog2(TEXT_W);
  localparam int DYW        = $clog2(TEXT_H);

  logic signed [AW-1:0] fw, fh, w, h, col, row;
  logic signed [AW-1:0] line, d, d_adj, top, dy, dx;
  logic                 in_frame, dy_ok, dx_ok, gap;
  logic [DXW-1:0]       dxu, cell_x;
  logic [DYW-1:0]       dyu;
  logic [3:0]           glyph;
  logic [2:0]           gy;
  logic [2:0]           gx;
  logic [stx_pkg::GLYPH_COLS-1:0] bits;

  always_comb begin
    fw  = $signed(AW'(cfg.frame_width));
    fh  = $signed(AW'(cfg.frame_height));
    w   = (fw > AW'(MAX_DIM)) ? AW'(MAX_DIM) : fw;
    h   = (fh > AW'(MAX_DIM)) ? AW'(MAX_DIM) : fh;
    col = $signed(AW'(column));
    row = $signed(AW'(buffer_row));
    in_frame = (col < w) && (row < h);

    // rows are stored bottom-up
    line  = h - AW'(1) - row;
    d     = h - AW'(TEXT_H);
    // halve with truncation toward zero
    d_adj = d + $signed({{(AW-1){1'b0}}, d[AW-1]});
    top   = d_adj >>> 1;
    dy    = line - top;
    dy_ok = !dy[AW-1] && (dy < AW'(TEXT_H));

    dx    = col - AW'(offset);
    dx_ok = !dx[AW-1] && (dx < AW'(TEXT_W));

    dxu = dx[DXW-1:0];
    dyu = dy[DYW-1:0];

    glyph = 4'd0;
    for (int k = 1; k < stx_pkg::GLYPH_COUNT; k++) begin
      if (dxu >= DXW'(k * CELL_PITCH)) begin
        glyph = 4'(k);
      end
    end
    cell_x = dxu - DXW'(glyph * CELL_PITCH);
    gap    = cell_x >= DXW'(stx_pkg::GLYPH_COLS * SCALE);

    gx = 3'd0;
    for (int k = 1; k < stx_pkg::GLYPH_COLS; k++) begin
      if (cell_x >= DXW'(k * SCALE)) begin
        gx = 3'(k);
      end
    end

    gy = 3'd0;
    for (int k = 1; k < stx_pkg::GLYPH_ROWS; k++) begin
      if (dyu >= DYW'(k * SCALE)) begin
        gy = 3'(k);
      end
    end

    bits = stx_pkg::GLYPH_ROM[glyph][gy];
    lit  = in_frame && dy_ok && dx_ok && !gap && bits[3'd4 - gx];
  end

endmodule

FILE: rtl/scrolling_text_pixel_generator.sv
// pipeline: an accepted transaction is held in the input register, then its result in the result register
// throughput: one transaction per cycle when out_ch.ready does not stall, set by the input
//   register and the result register around a single pass of coordinate and font lookup logic
// reset: synchronous active-low rst_n clears the pipeline valids and scroll offset
//   and loads the default frame size and scroll step
module scrolling_text_pixel_generator #(
  parameter int SCALE   = stx_pkg::SCALE_DEF,
  parameter int MAX_DIM = stx_pkg::MAX_DIM_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  stx_in_if.sink                          in_ch,
  stx_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [stx_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [stx_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int OFS_W = $clog2(MAX_DIM + 1024) + 1;

  stx_pkg::cfg_t           cfg;
  logic signed [OFS_W-1:0] offset;
  logic                    lit;

  logic                        s1_valid_r, s1_valid_nxt;
  logic [stx_pkg::COORD_W-1:0] s1_col_r;
  logic [stx_pkg::COORD_W-1:0] s1_row_r;
  logic                        s1_end_r;
  logic                        out_valid_r, out_valid_nxt;
  logic [stx_pkg::PIXEL_W-1:0] out_pixel_r;
  logic                        s1_move;
  logic                        in_take;

  assign s1_move     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_move;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt  = in_take || (s1_valid_r && !s1_move);
    out_valid_nxt = s1_move || (out_valid_r && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_col_r <= in_ch.column;
      s1_row_r <= in_ch.buffer_row;
      s1_end_r <= in_ch.frame_end;
    end
    if (s1_move) begin
      out_pixel_r <= lit ? stx_pkg::PIXEL_ON : stx_pkg::PIXEL_OFF;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.pixel_value = out_pixel_r;

  stx_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  stx_scroll #(
    .SCALE   (SCALE),
    .MAX_DIM (MAX_DIM)
  ) u_scroll (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (s1_move && s1_end_r),
    .cfg     (cfg),
    .offset  (offset)
  );

  stx_pixel_core #(
    .SCALE   (SCALE),
    .MAX_DIM (MAX_DIM)
  ) u_core (
    .column     (s1_col_r),
    .buffer_row (s1_row_r),
    .cfg        (cfg),
    .offset     (offset),
    .lit        (lit)
  );

endmodule
